@@ hdl/ucp_pkg.sv @@
// shared constants and types for the setting command parser
`default_nettype none
package ucp_pkg;

  // character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_VT    = 8'h0b;
  localparam logic [7:0] CH_FF    = 8'h0c;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_UP_H  = 8'h48;
  localparam logic [7:0] CH_UP_P  = 8'h50;
  localparam logic [7:0] CH_UP_T  = 8'h54;
  localparam logic [7:0] CH_LO_H  = 8'h68;
  localparam logic [7:0] CH_LO_P  = 8'h70;
  localparam logic [7:0] CH_LO_T  = 8'h74;

  localparam int LINE_BYTES_DEF = 64;

  localparam logic [31:0] PERIOD_RST = 32'd4000;
  localparam logic [6:0]  TEMP_RST   = 7'd29;
  localparam logic [6:0]  HUM_RST    = 7'd70;
  localparam logic [6:0]  LIMIT_MAX  = 7'd99;

  // settings gathered over one line, handed over at its end
  typedef struct packed {
    logic        p_valid;
    logic [31:0] p_val;
    logic        t_valid;
    logic [6:0]  t_val;
    logic        h_valid;
    logic [6:0]  h_val;
  } line_evt_t;

endpackage
`default_nettype wire

@@ hdl/ucp_line_parser.sv @@
// input register, line and token tracking, number accumulation
`default_nettype none
module ucp_line_parser
  import ucp_pkg::*;
#(
  parameter int LINE_BYTES = LINE_BYTES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_rx_byte,
  output logic            evt_valid,
  input  wire logic       evt_ready,
  output line_evt_t       evt
);

  localparam int LW = $clog2(LINE_BYTES);

  localparam logic [2:0] PH_BETWEEN = 3'd0;
  localparam logic [2:0] PH_EQUALS  = 3'd1;
  localparam logic [2:0] PH_SPACE   = 3'd2;
  localparam logic [2:0] PH_SIGN    = 3'd3;
  localparam logic [2:0] PH_DIGITS  = 3'd4;
  localparam logic [2:0] PH_SKIP    = 3'd5;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_P    = 2'd1;
  localparam logic [1:0] KIND_T    = 2'd2;
  localparam logic [1:0] KIND_H    = 2'd3;

  logic          byte_v_r;
  logic [7:0]    byte_r;
  logic [LW-1:0] len_r,   len_nxt;
  logic          cut_r,   cut_nxt;
  logic [2:0]    phase_r, phase_nxt;
  logic [1:0]    kind_r,  kind_nxt;
  logic          neg_r,   neg_nxt;
  logic [31:0]   acc_r,   acc_nxt;
  logic          ovf_r,   ovf_nxt;
  line_evt_t     pend_r,  pend_nxt;

  logic        go, term, sep, dig, do_finish, clear;
  logic [35:0] prod;
  logic [31:0] acc_dig, fin_v;
  logic        ovf_dig;
  line_evt_t   pend_f;

  assign term = (byte_r == CH_LF) || (byte_r == CH_CR) || (byte_r == CH_SEMI);
  assign sep  = (byte_r == CH_SPACE) || (byte_r == CH_COMMA);
  assign dig  = (byte_r >= CH_ZERO) && (byte_r <= CH_NINE);

  // a line end with bytes held needs the result side free
  assign evt_valid = byte_v_r && term && (len_r != '0);
  assign go        = byte_v_r && (!evt_valid || evt_ready);
  assign in_ready  = !byte_v_r || go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_v_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      byte_v_r <= 1'b1;
    end else if (go) begin
      byte_v_r <= 1'b0;
    end
    if (in_valid && in_ready) begin
      byte_r <= in_rx_byte;
    end
  end

  // acc * 10 + digit, saturating
  assign prod    = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0}
                 + {32'd0, byte_r[3:0] - CH_ZERO[3:0]};
  assign ovf_dig = ovf_r || (prod[35:32] != 4'd0);
  assign acc_dig = ovf_dig ? 32'hffff_ffff : prod[31:0];

  // value of the number being read, as if it ended now
  assign fin_v = (neg_r && !ovf_r) ? 32'(32'd0 - acc_r) : acc_r;

  always_comb begin
    pend_f = pend_r;
    if (do_finish) begin
      if (kind_r == KIND_P) begin
        pend_f.p_valid = 1'b1;
        pend_f.p_val   = fin_v;
      end
      if ((kind_r == KIND_T) && (fin_v <= 32'(LIMIT_MAX))) begin
        pend_f.t_valid = 1'b1;
        pend_f.t_val   = fin_v[6:0];
      end
      if ((kind_r == KIND_H) && (fin_v <= 32'(LIMIT_MAX))) begin
        pend_f.h_valid = 1'b1;
        pend_f.h_val   = fin_v[6:0];
      end
    end
  end

  assign evt = pend_f;

  always_comb begin
    len_nxt   = len_r;
    cut_nxt   = cut_r;
    phase_nxt = phase_r;
    kind_nxt  = kind_r;
    neg_nxt   = neg_r;
    acc_nxt   = acc_r;
    ovf_nxt   = ovf_r;
    do_finish = 1'b0;
    clear     = 1'b0;
    if (term) begin
      do_finish = (len_r != '0) && !cut_r && (phase_r == PH_DIGITS);
      clear     = 1'b1;
    end else if (len_r >= LW'(LINE_BYTES - 1)) begin
      // overlong line is thrown away
      clear = 1'b1;
    end else begin
      len_nxt = len_r + LW'(1);
      if (cut_r) begin
        // rest of line after a nul is ignored
      end else if (byte_r == CH_NUL) begin
        do_finish = (phase_r == PH_DIGITS);
        phase_nxt = PH_SKIP;
        cut_nxt   = 1'b1;
      end else begin
        case (phase_r)
          PH_BETWEEN: begin
            if (!sep) begin
              neg_nxt = 1'b0;
              acc_nxt = 32'd0;
              ovf_nxt = 1'b0;
              if ((byte_r == CH_UP_P) || (byte_r == CH_LO_P)) begin
                kind_nxt = KIND_P;
              end else if ((byte_r == CH_UP_T) || (byte_r == CH_LO_T)) begin
                kind_nxt = KIND_T;
              end else if ((byte_r == CH_UP_H) || (byte_r == CH_LO_H)) begin
                kind_nxt = KIND_H;
              end else begin
                kind_nxt = KIND_NONE;
              end
              phase_nxt = (kind_nxt == KIND_NONE) ? PH_SKIP : PH_EQUALS;
            end
          end
          PH_EQUALS: begin
            if (sep) begin
              phase_nxt = PH_BETWEEN;
            end else begin
              phase_nxt = (byte_r == CH_EQ) ? PH_SPACE : PH_SKIP;
            end
          end
          PH_SPACE: begin
            if (sep) begin
              phase_nxt = PH_BETWEEN;
            end else if ((byte_r == CH_TAB) || (byte_r == CH_VT) || (byte_r == CH_FF)) begin
              phase_nxt = PH_SPACE;
            end else if ((byte_r == CH_PLUS) || (byte_r == CH_MINUS)) begin
              neg_nxt   = (byte_r == CH_MINUS);
              phase_nxt = PH_SIGN;
            end else if (dig) begin
              acc_nxt   = acc_dig;
              ovf_nxt   = ovf_dig;
              phase_nxt = PH_DIGITS;
            end else begin
              phase_nxt = PH_SKIP;
            end
          end
          PH_SIGN: begin
            if (sep) begin
              phase_nxt = PH_BETWEEN;
            end else if (dig) begin
              acc_nxt   = acc_dig;
              ovf_nxt   = ovf_dig;
              phase_nxt = PH_DIGITS;
            end else begin
              phase_nxt = PH_SKIP;
            end
          end
          PH_DIGITS: begin
            if (dig) begin
              acc_nxt = acc_dig;
              ovf_nxt = ovf_dig;
            end else begin
              do_finish = 1'b1;
              phase_nxt = sep ? PH_BETWEEN : PH_SKIP;
            end
          end
          default: begin
            if (sep) begin
              phase_nxt = PH_BETWEEN;
            end
          end
        endcase
      end
    end
    pend_nxt = pend_f;
    if (clear) begin
      len_nxt   = '0;
      cut_nxt   = 1'b0;
      phase_nxt = PH_BETWEEN;
      kind_nxt  = KIND_NONE;
      neg_nxt   = 1'b0;
      acc_nxt   = 32'd0;
      ovf_nxt   = 1'b0;
      pend_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= '0;
      cut_r   <= 1'b0;
      phase_r <= PH_BETWEEN;
      kind_r  <= KIND_NONE;
      neg_r   <= 1'b0;
      acc_r   <= 32'd0;
      ovf_r   <= 1'b0;
      pend_r  <= '0;
    end else if (go) begin
      len_r   <= len_nxt;
      cut_r   <= cut_nxt;
      phase_r <= phase_nxt;
      kind_r  <= kind_nxt;
      neg_r   <= neg_nxt;
      acc_r   <= acc_nxt;
      ovf_r   <= ovf_nxt;
      pend_r  <= pend_nxt;
    end
  end

endmodule
`default_nettype wire

@@ hdl/ucp_settings.sv @@
// setting registers and the result register
`default_nettype none
module ucp_settings
  import ucp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        evt_valid,
  output logic             evt_ready,
  input  wire line_evt_t   evt,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_status,
  output logic             out_period_written,
  output logic [31:0]      out_period_value,
  output logic [15:0]      out_reload_value,
  output logic [6:0]       out_temp_threshold,
  output logic [6:0]       out_hum_threshold
);

  logic        period_r_v;
  logic [31:0] period_r, period_nxt;
  logic [6:0]  temp_r,   temp_nxt;
  logic [6:0]  hum_r,    hum_nxt;
  logic        out_valid_r;
  logic        status_r, written_r;
  logic [31:0] oper_r;
  logic [15:0] reload_r;
  logic [6:0]  otemp_r, ohum_r;
  logic        fire;

  assign evt_ready  = !out_valid_r || out_ready;
  assign fire       = evt_valid && evt_ready;
  assign period_r_v = evt.p_valid;

  assign period_nxt = period_r_v  ? evt.p_val : period_r;
  assign temp_nxt   = evt.t_valid ? evt.t_val : temp_r;
  assign hum_nxt    = evt.h_valid ? evt.h_val : hum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r    <= PERIOD_RST;
      temp_r      <= TEMP_RST;
      hum_r       <= HUM_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        period_r    <= period_nxt;
        temp_r      <= temp_nxt;
        hum_r       <= hum_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (fire) begin
      status_r  <= !(evt.p_valid || evt.t_valid || evt.h_valid);
      written_r <= evt.p_valid;
      oper_r    <= period_nxt;
      // reload is period minus one, low half only
      reload_r  <= period_nxt[15:0] - 16'd1;
      otemp_r   <= temp_nxt;
      ohum_r    <= hum_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_period_written = written_r;
  assign out_period_value   = oper_r;
  assign out_reload_value   = reload_r;
  assign out_temp_threshold = otemp_r;
  assign out_hum_threshold  = ohum_r;

  a_limits_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (temp_r <= LIMIT_MAX) && (hum_r <= LIMIT_MAX))
    else $error("threshold setting above limit");

  a_result_matches_settings: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> (out_period_value == period_r) && (out_temp_threshold == temp_r)
             && (out_hum_threshold == hum_r))
    else $error("result does not match stored settings");

  a_written_means_ack: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_period_written) |-> !out_status)
    else $error("period written but status is a format hint");

  a_reload_follows_period: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_reload_value == 16'(out_period_value[15:0] - 16'd1)))
    else $error("reload value out of step with period");

  a_settings_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(period_r) && $stable(temp_r) && $stable(hum_r))
    else $error("settings changed without a line end");

endmodule
`default_nettype wire

@@ hdl/uart_setting_command_parser.sv @@
// top level of the serial setting command parser
// Takes one received character per item and can accept an item every cycle. A byte
// sits in an input register while the line and token state is updated, and a line
// end that carries bytes passes from that register into the result register, which
// raises out_valid; the result is then held until it is taken. The only stall is a
// line end arriving while the previous result is still waiting to be taken; ordinary
// bytes keep flowing. Settings change only when a line ends: the last valid P, T and H
// value in the line wins, and T or H above 99 is ignored. A character that would make
// a line longer than LINE_BYTES-1 throws the line away without a result, and the
// bytes after it are parsed as a new line.
`default_nettype none
module uart_setting_command_parser
  import ucp_pkg::*;
#(
  parameter int LINE_BYTES = LINE_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_status,
  output logic             out_period_written,
  output logic [31:0]      out_period_value,
  output logic [15:0]      out_reload_value,
  output logic [6:0]       out_temp_threshold,
  output logic [6:0]       out_hum_threshold
);

  logic      evt_valid;
  logic      evt_ready;
  line_evt_t evt;

  ucp_line_parser #(
    .LINE_BYTES (LINE_BYTES)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .evt_valid  (evt_valid),
    .evt_ready  (evt_ready),
    .evt        (evt)
  );

  ucp_settings u_settings (
    .clk                (clk),
    .rst_n              (rst_n),
    .evt_valid          (evt_valid),
    .evt_ready          (evt_ready),
    .evt                (evt),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_period_written (out_period_written),
    .out_period_value   (out_period_value),
    .out_reload_value   (out_reload_value),
    .out_temp_threshold (out_temp_threshold),
    .out_hum_threshold  (out_hum_threshold)
  );

endmodule
`default_nettype wire
